// ===== design/assert_macros.svh =====
// assertion macros shared by the demux rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checks a property at every rising clock edge outside reset
`define CCD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checks that a condition leads to another one in the next cycle
`define CCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/ccd_pkg.sv =====
// types, codes and constants of the camera container demux
`default_nettype none

package ccd_pkg;

  typedef enum logic [3:0] {
    PH_HEADER,
    PH_CODE,
    PH_LEN,
    PH_ATS,
    PH_ASKIP,
    PH_APAY,
    PH_VTS,
    PH_VSKIP,
    PH_VPAY,
    PH_DONE,
    PH_DEAD
  } phase_t;

  typedef enum logic [2:0] {
    KIND_ABYTE     = 3'd0,
    KIND_VBYTE     = 3'd1,
    KIND_ATIME     = 3'd2,
    KIND_VTIME     = 3'd3,
    KIND_DURATION  = 3'd4,
    KIND_END       = 3'd5,
    KIND_UNKNOWN   = 3'd6,
    KIND_BAD_MAGIC = 3'd7
  } kind_t;

  localparam logic [31:0] TAG_HXVS = 32'h4858_5653;
  localparam logic [31:0] TAG_HXAF = 32'h4858_4146;
  localparam logic [31:0] TAG_HXVF = 32'h4858_5646;
  localparam logic [31:0] TAG_HXFI = 32'h4858_4649;

  localparam logic [4:0] NAL_SEI = 5'h06;
  localparam logic [4:0] NAL_SPS = 5'h07;
  localparam logic [4:0] NAL_PPS = 5'h08;

  localparam int unsigned FC_W = 4;

  localparam logic [FC_W-1:0] FC_FIELD_LAST = 4'd3;
  localparam logic [FC_W-1:0] FC_MAGIC_LAST = 4'd3;
  localparam logic [FC_W-1:0] FC_DUR_FIRST  = 4'd8;
  localparam logic [FC_W-1:0] FC_DUR_LAST   = 4'd11;
  localparam logic [FC_W-1:0] FC_HDR_LAST   = 4'd15;
  localparam logic [FC_W-1:0] FC_ASKIP_LAST = 4'd7;
  localparam logic [FC_W-1:0] FC_NAL_POS    = 4'd4;

  localparam logic [31:0] AUDIO_HDR_BYTES = 32'd4;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [31:0] value;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

`default_nettype wire

// ===== design/camera_container_demux_top.sv =====
// top level of the camera container demux
//
// input channel: one container file byte per transaction on in_byte, with
// in_valid and in_stall. output channel: one result per transaction
// (out_kind, out_byte, out_value, out_last), with out_valid and out_stall.
// out_last marks the final result caused by one input byte.
// a byte is parsed in the cycle it is taken; its results are written into
// the result queue at the end of that cycle. one byte is taken every cycle
// while in_stall is low; the fifth byte of a video payload may give two
// results, which leave one per cycle while out_stall is low. in_stall rises
// when the result queue has room for fewer than two results, so a stalled
// receiver holds the input back after a few results. results wait in the queue
// unchanged while out_stall is high. reset clears the parser to the start of
// the file header and empties the queue. after the end record or a bad magic,
// input bytes are still taken but give no results until the next reset.
`default_nettype none

module camera_container_demux_top
  import ccd_pkg::*;
#(
  parameter int unsigned OUT_DEPTH = QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_byte,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [2:0]             out_kind,
  output logic [7:0]             out_byte,
  output logic signed [31:0]     out_value,
  output logic                   out_last
);

  logic    in_accept;
  logic    room;
  push_t   push;
  result_t head;

  assign in_stall  = !room;
  assign in_accept = in_valid && room;

  ccd_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept_i (in_accept),
    .byte_i   (in_byte),
    .push_o   (push)
  );

  ccd_outq #(
    .DEPTH (OUT_DEPTH)
  ) u_outq (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .head_o      (head)
  );

  assign out_kind  = head.kind;
  assign out_byte  = head.data;
  assign out_value = $signed(head.value);
  assign out_last  = head.last;

endmodule

`default_nettype wire

// ===== design/ccd_parser.sv =====
// byte parser: header check, record decode and result generation
`default_nettype none
`include "assert_macros.svh"

module ccd_parser
  import ccd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept_i,
  input  wire logic [7:0] byte_i,
  output push_t           push_o
);

  phase_t            phase_r, phase_nxt;
  logic [FC_W-1:0]   fc_r, fc_nxt;
  logic [31:0]       code_r, code_nxt;
  logic [31:0]       len_r, len_nxt;
  logic [31:0]       ts_r, ts_nxt;
  logic [31:0]       afirst_r, afirst_nxt;
  logic              aseen_r, aseen_nxt;
  logic [31:0]       vfirst_r, vfirst_nxt;
  logic              vseen_r, vseen_nxt;
  logic [31:0]       total_r, total_nxt;

  logic [31:0] code_sh;
  logic [31:0] byte_lane;
  logic [31:0] ts_ins;
  logic [31:0] len_ins;
  logic [31:0] len_less;
  logic [FC_W-1:0] fc_inc;
  logic        bad_magic;
  logic [4:0]  nal;
  push_t       push;

  assign code_sh   = {code_r[23:0], byte_i};
  assign byte_lane = {24'd0, byte_i} << {fc_r[1:0], 3'b000};
  assign ts_ins    = ts_r | byte_lane;
  assign len_ins   = len_r | byte_lane;
  assign len_less  = len_r - AUDIO_HDR_BYTES;
  assign fc_inc    = fc_r + 1'b1;
  assign bad_magic = (fc_r == FC_MAGIC_LAST) && (code_sh != TAG_HXVS);
  assign nal       = byte_i[4:0];

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    fc_nxt     = fc_r;
    code_nxt   = code_r;
    len_nxt    = len_r;
    ts_nxt     = ts_r;
    afirst_nxt = afirst_r;
    aseen_nxt  = aseen_r;
    vfirst_nxt = vfirst_r;
    vseen_nxt  = vseen_r;
    total_nxt  = total_r;
    unique case (phase_r)
      PH_HEADER: begin
        if (fc_r <= FC_MAGIC_LAST) begin
          code_nxt = code_sh;
        end
        if (bad_magic) begin
          phase_nxt = PH_DEAD;
        end else begin
          if (fc_r >= FC_DUR_FIRST && fc_r <= FC_DUR_LAST) begin
            ts_nxt = ts_ins;
          end
          if (fc_r == FC_HDR_LAST) begin
            fc_nxt    = '0;
            code_nxt  = '0;
            phase_nxt = PH_CODE;
          end else begin
            fc_nxt = fc_inc;
          end
        end
      end
      PH_CODE: begin
        code_nxt = code_sh;
        if (fc_r == FC_FIELD_LAST) begin
          fc_nxt    = '0;
          len_nxt   = '0;
          phase_nxt = PH_LEN;
        end else begin
          fc_nxt = fc_inc;
        end
      end
      PH_LEN: begin
        len_nxt = len_ins;
        if (fc_r == FC_FIELD_LAST) begin
          fc_nxt = '0;
          ts_nxt = '0;
          if (code_r == TAG_HXAF) begin
            phase_nxt = PH_ATS;
          end else if (code_r == TAG_HXVF) begin
            phase_nxt = PH_VTS;
          end else if (code_r == TAG_HXFI) begin
            phase_nxt = PH_DONE;
          end else begin
            phase_nxt = PH_CODE;
          end
        end else begin
          fc_nxt = fc_inc;
        end
      end
      PH_ATS: begin
        ts_nxt = ts_ins;
        if (fc_r == FC_FIELD_LAST) begin
          fc_nxt = '0;
          if (!aseen_r) begin
            afirst_nxt = ts_ins;
            aseen_nxt  = 1'b1;
          end
          phase_nxt = PH_ASKIP;
        end else begin
          fc_nxt = fc_inc;
        end
      end
      PH_VTS: begin
        ts_nxt = ts_ins;
        if (fc_r == FC_FIELD_LAST) begin
          fc_nxt = '0;
          if (!vseen_r) begin
            vfirst_nxt = ts_ins;
            vseen_nxt  = 1'b1;
          end
          phase_nxt = PH_VSKIP;
        end else begin
          fc_nxt = fc_inc;
        end
      end
      PH_ASKIP: begin
        if (fc_r == FC_ASKIP_LAST) begin
          fc_nxt = '0;
          if (len_r[31] || len_r < AUDIO_HDR_BYTES) begin
            len_nxt   = '0;
            phase_nxt = PH_CODE;
          end else begin
            len_nxt   = len_less;
            phase_nxt = (len_less != '0) ? PH_APAY : PH_CODE;
          end
        end else begin
          fc_nxt = fc_inc;
        end
      end
      PH_APAY: begin
        total_nxt = total_r + 32'd1;
        len_nxt   = len_r - 32'd1;
        if (len_r == 32'd1) begin
          phase_nxt = PH_CODE;
        end
      end
      PH_VSKIP: begin
        if (fc_r == FC_FIELD_LAST) begin
          fc_nxt = '0;
          if (len_r[31]) begin
            len_nxt   = '0;
            phase_nxt = PH_CODE;
          end else begin
            phase_nxt = (len_r != '0) ? PH_VPAY : PH_CODE;
          end
        end else begin
          fc_nxt = fc_inc;
        end
      end
      PH_VPAY: begin
        if (fc_r <= FC_NAL_POS) begin
          fc_nxt = fc_inc;
        end
        len_nxt = len_r - 32'd1;
        if (len_r == 32'd1) begin
          fc_nxt    = '0;
          phase_nxt = PH_CODE;
        end
      end
      PH_DONE, PH_DEAD: begin
      end
      default: begin
        phase_nxt = PH_DEAD;
      end
    endcase
  end

  // results
  always_comb begin
    push          = '0;
    push.r0.kind  = KIND_ABYTE;
    push.r1.kind  = KIND_ABYTE;
    unique case (phase_r)
      PH_HEADER: begin
        if (bad_magic) begin
          push.cnt     = 2'd1;
          push.r0.kind = KIND_BAD_MAGIC;
        end else if (fc_r == FC_DUR_LAST) begin
          push.cnt      = 2'd1;
          push.r0.kind  = KIND_DURATION;
          push.r0.value = ts_ins;
        end
      end
      PH_LEN: begin
        if (fc_r == FC_FIELD_LAST) begin
          if (code_r == TAG_HXFI) begin
            push.cnt      = 2'd1;
            push.r0.kind  = KIND_END;
            push.r0.value = total_r;
          end else if (code_r != TAG_HXAF && code_r != TAG_HXVF) begin
            push.cnt     = 2'd1;
            push.r0.kind = KIND_UNKNOWN;
          end
        end
      end
      PH_ATS: begin
        if (fc_r == FC_FIELD_LAST) begin
          push.cnt      = 2'd1;
          push.r0.kind  = KIND_ATIME;
          push.r0.value = aseen_r ? (ts_ins - afirst_r) : 32'd0;
        end
      end
      PH_APAY: begin
        push.cnt     = 2'd1;
        push.r0.kind = KIND_ABYTE;
        push.r0.data = byte_i;
      end
      PH_VPAY: begin
        push.cnt     = 2'd1;
        push.r0.kind = KIND_VBYTE;
        push.r0.data = byte_i;
        if (fc_r == FC_NAL_POS) begin
          case (nal) inside
            NAL_SEI, NAL_SPS, NAL_PPS: begin
            end
            default: begin
              push.cnt      = 2'd2;
              push.r1.kind  = KIND_VTIME;
              push.r1.value = ts_r - vfirst_r;
            end
          endcase
        end
      end
      PH_CODE, PH_VTS, PH_ASKIP, PH_VSKIP, PH_DONE, PH_DEAD: begin
      end
      default: begin
      end
    endcase
    if (!accept_i) begin
      push.cnt = 2'd0;
    end
    push.r0.last = (push.cnt == 2'd1);
    push.r1.last = 1'b1;
  end

  assign push_o = push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      fc_r     <= '0;
      code_r   <= '0;
      len_r    <= '0;
      ts_r     <= '0;
      afirst_r <= '0;
      aseen_r  <= 1'b0;
      vfirst_r <= '0;
      vseen_r  <= 1'b0;
      total_r  <= '0;
    end else if (accept_i) begin
      phase_r  <= phase_nxt;
      fc_r     <= fc_nxt;
      code_r   <= code_nxt;
      len_r    <= len_nxt;
      ts_r     <= ts_nxt;
      afirst_r <= afirst_nxt;
      aseen_r  <= aseen_nxt;
      vfirst_r <= vfirst_nxt;
      vseen_r  <= vseen_nxt;
      total_r  <= total_nxt;
    end
  end

  `CCD_ASSERT(a_quiet_after_end, (phase_r == PH_DONE || phase_r == PH_DEAD) |-> (push.cnt == 2'd0), "result after end of stream")
  `CCD_ASSERT(a_pair_only_video, (push.cnt == 2'd2) |-> (phase_r == PH_VPAY && fc_r == FC_NAL_POS), "result pair outside video payload")
  `CCD_ASSERT(a_payload_len_live, (phase_r == PH_APAY || phase_r == PH_VPAY) |-> (len_r != '0), "payload phase with zero length")

endmodule

`default_nettype wire

// ===== design/ccd_outq.sv =====
// result queue that takes up to two results per cycle and hands out one while out_stall_i is low
`default_nettype none
`include "assert_macros.svh"

module ccd_outq
  import ccd_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push_i,
  output logic       room_o,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  output result_t    head_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  result_t         mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [PW-1:0]   wr_ptr_p1;
  logic            pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_ptr_p1   = ptr_inc(wr_ptr_r);
  assign out_valid_o = (count_r != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign room_o      = (count_r <= CW'(DEPTH - 2));
  assign head_o      = mem_r[rd_ptr_r];

  always_comb begin
    case (push_i.cnt)
      2'd1:    wr_ptr_nxt = wr_ptr_p1;
      2'd2:    wr_ptr_nxt = ptr_inc(wr_ptr_p1);
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CW'(push_i.cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_i.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_r[wr_ptr_p1] <= push_i.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `CCD_ASSERT(a_count_bound, count_r <= CW'(DEPTH), "queue count beyond depth")
  `CCD_ASSERT(a_push_has_room, (push_i.cnt != 2'd0) |-> room_o, "push without room for a pair")
  `CCD_ASSERT_NEXT(a_pair_grows, (push_i.cnt == 2'd2 && !pop), count_r == $past(count_r) + CW'(2), "result pair not stored")

endmodule

`default_nettype wire

// ===== dv/camera_container_demux_top_tb.sv =====
// testbench for camera_container_demux_top: directed and random container streams, checked per result
`default_nettype none

module camera_container_demux_top_tb;
  import ccd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned RANDOM_BYTES = 2000;
  localparam int unsigned SETTLE_CYCLES = 16;

  typedef struct {
    kind_t       kind;
    logic [7:0]  data;
    logic [31:0] value;
    logic        last;
  } demux_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_byte = 8'd0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_kind;
  logic [7:0] out_byte;
  logic signed [31:0] out_value;
  logic out_last;

  demux_result_t awaited_results[$];
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned stall_left = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;

  // parser state mirrored from the block
  phase_t pr_phase = PH_HEADER;
  logic [31:0] pr_field = '0;
  logic [31:0] pr_code = '0;
  logic [31:0] pr_len = '0;
  logic [31:0] pr_ts = '0;
  logic [31:0] pr_first_audio = '0;
  logic [31:0] pr_first_video = '0;
  logic [31:0] pr_audio_total = '0;
  logic pr_audio_seen = 1'b0;
  logic pr_video_seen = 1'b0;

  logic [31:0] audio_clock;
  logic [31:0] video_clock;

  camera_container_demux_top DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte(in_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_byte(out_byte),
    .out_value(out_value),
    .out_last(out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin : rx_pacing
    int unsigned hold;
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (rx_steady) begin
      out_stall <= 1'b0;
    end else begin
      hold = idle_length();
      out_stall <= (hold != 0);
      stall_left <= (hold == 0) ? 0 : hold - 1;
    end
  end

  function automatic demux_result_t result_of(kind_t k, logic [7:0] d, logic [31:0] v);
    demux_result_t r;
    r.kind = k;
    r.data = d;
    r.value = v;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic demux_byte(input logic [7:0] b);
    demux_result_t caused[$];
    logic [4:0] nal;
    case (pr_phase)
      PH_HEADER: begin
        if (pr_field < 4) pr_code = {pr_code[23:0], b};
        if (pr_field == 3 && pr_code != TAG_HXVS) begin
          caused.push_back(result_of(KIND_BAD_MAGIC, 8'd0, 32'd0));
          pr_phase = PH_DEAD;
        end else begin
          if (pr_field >= 8 && pr_field < 12) pr_ts |= 32'(b) << (8 * (pr_field - 8));
          if (pr_field == 11) caused.push_back(result_of(KIND_DURATION, 8'd0, pr_ts));
          pr_field++;
          if (pr_field >= 16) begin
            pr_field = 0;
            pr_code = 0;
            pr_phase = PH_CODE;
          end
        end
      end
      PH_CODE: begin
        pr_code = {pr_code[23:0], b};
        pr_field++;
        if (pr_field >= 4) begin
          pr_field = 0;
          pr_len = 0;
          pr_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        pr_len |= 32'(b) << (8 * pr_field[1:0]);
        pr_field++;
        if (pr_field >= 4) begin
          pr_field = 0;
          pr_ts = 0;
          if (pr_code == TAG_HXAF) begin
            pr_phase = PH_ATS;
          end else if (pr_code == TAG_HXVF) begin
            pr_phase = PH_VTS;
          end else if (pr_code == TAG_HXFI) begin
            caused.push_back(result_of(KIND_END, 8'd0, pr_audio_total));
            pr_phase = PH_DONE;
          end else begin
            caused.push_back(result_of(KIND_UNKNOWN, 8'd0, 32'd0));
            pr_phase = PH_CODE;
          end
        end
      end
      PH_ATS, PH_VTS: begin
        pr_ts |= 32'(b) << (8 * pr_field[1:0]);
        pr_field++;
        if (pr_field >= 4) begin
          pr_field = 0;
          if (pr_phase == PH_ATS) begin
            if (!pr_audio_seen) begin
              pr_first_audio = pr_ts;
              pr_audio_seen = 1'b1;
            end
            caused.push_back(result_of(KIND_ATIME, 8'd0, pr_ts - pr_first_audio));
            pr_phase = PH_ASKIP;
          end else begin
            if (!pr_video_seen) begin
              pr_first_video = pr_ts;
              pr_video_seen = 1'b1;
            end
            pr_phase = PH_VSKIP;
          end
        end
      end
      PH_ASKIP: begin
        pr_field++;
        if (pr_field >= 8) begin
          pr_field = 0;
          if (pr_len[31] || pr_len < 4) pr_len = 0;
          else pr_len -= 4;
          pr_phase = (pr_len != 0) ? PH_APAY : PH_CODE;
        end
      end
      PH_APAY: begin
        caused.push_back(result_of(KIND_ABYTE, b, 32'd0));
        pr_audio_total++;
        pr_len--;
        if (pr_len == 0) pr_phase = PH_CODE;
      end
      PH_VSKIP: begin
        pr_field++;
        if (pr_field >= 4) begin
          pr_field = 0;
          if (pr_len[31]) pr_len = 0;
          pr_phase = (pr_len != 0) ? PH_VPAY : PH_CODE;
        end
      end
      PH_VPAY: begin
        caused.push_back(result_of(KIND_VBYTE, b, 32'd0));
        if (pr_field == 4) begin
          nal = b[4:0];
          if (nal != NAL_SEI && nal != NAL_SPS && nal != NAL_PPS)
            caused.push_back(result_of(KIND_VTIME, 8'd0, pr_ts - pr_first_video));
        end
        if (pr_field < 5) pr_field++;
        pr_len--;
        if (pr_len == 0) begin
          pr_field = 0;
          pr_phase = PH_CODE;
        end
      end
      default: ;
    endcase
    if (caused.size() != 0) caused[caused.size() - 1].last = 1'b1;
    foreach (caused[i]) awaited_results.push_back(caused[i]);
  endtask

  always @(posedge clk) begin : result_check
    demux_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $display("%0t unexpected result: expected none, actual kind %0d byte %02h value %08h last %0b",
                 $time, out_kind, out_byte, out_value, out_last);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        if (out_kind !== want.kind || out_byte !== want.data || out_value !== want.value ||
            out_last !== want.last) begin
          $display("%0t mismatch: expected kind %0d byte %02h value %08h last %0b,",
                   $time, want.kind, want.data, want.value, want.last,
                   " actual kind %0d byte %02h value %08h last %0b",
                   out_kind, out_byte, out_value, out_last);
          errors++;
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = tx_steady ? 0 : idle_length();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (in_stall);
    demux_byte(b);
    bytes_sent++;
  endtask

  task automatic send_tag(input logic [31:0] tag);
    for (int i = 3; i >= 0; i--) send_byte(tag[8*i +: 8]);
  endtask

  task automatic send_le32(input logic [31:0] w);
    for (int i = 0; i < 4; i++) send_byte(w[8*i +: 8]);
  endtask

  function automatic int unsigned payload_bytes(logic [31:0] tag, logic [31:0] len);
    if (len[31]) return 0;
    if (tag == TAG_HXAF) return (len < 4) ? 0 : len - 4;
    if (tag == TAG_HXVF) return len;
    return 0;
  endfunction

  task automatic send_record(input logic [31:0] tag, input logic [31:0] len,
                             input logic [31:0] ts, input int unsigned n_pay,
                             input logic [7:0] nal);
    send_tag(tag);
    send_le32(len);
    if (tag == TAG_HXAF || tag == TAG_HXVF) begin
      send_le32(ts);
      repeat ((tag == TAG_HXAF) ? 8 : 4) send_byte(8'($urandom));
      for (int unsigned i = 0; i < n_pay; i++)
        send_byte((tag == TAG_HXVF && i == 4) ? nal : 8'($urandom));
    end
  endtask

  // pad with zero bytes until the parser waits for a fresh record code
  task automatic resync();
    while (!(pr_phase == PH_CODE && pr_field == 0)) send_byte(8'h00);
  endtask

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(0, 3))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      default: return 32'h8000_0000;
    endcase
  endfunction

  function automatic logic [31:0] next_time(logic [31:0] prev);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return prev + $urandom_range(0, 2000);
    if (r < 90) return $urandom;
    return pick_extreme();
  endfunction

  function automatic logic [31:0] audio_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(4, 40);
    if (r < 85) return $urandom_range(0, 3);
    if (r < 93) return {1'b1, 31'($urandom)};
    return $urandom_range(41, 300);
  endfunction

  function automatic logic [31:0] video_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(5, 40);
    if (r < 82) return $urandom_range(0, 4);
    if (r < 90) return {1'b1, 31'($urandom)};
    return $urandom_range(41, 300);
  endfunction

  function automatic logic [7:0] nal_byte();
    logic [4:0] low;
    if ($urandom_range(0, 99) < 40) begin
      case ($urandom_range(0, 2))
        0: low = NAL_SEI;
        1: low = NAL_SPS;
        default: low = NAL_PPS;
      endcase
      return {3'($urandom), low};
    end
    return 8'($urandom);
  endfunction

  function automatic logic [31:0] unknown_code();
    logic [31:0] c;
    do begin
      case ($urandom_range(0, 3))
        0: c = TAG_HXVS;
        1: c = TAG_HXAF ^ (32'd1 << $urandom_range(0, 31));
        2: c = TAG_HXVF ^ (32'd1 << $urandom_range(0, 31));
        default: c = $urandom;
      endcase
    end while (c == TAG_HXAF || c == TAG_HXVF || c == TAG_HXFI);
    return c;
  endfunction

  task automatic test_file_header();
    send_tag(TAG_HXVS);
    repeat (4) send_byte(8'($urandom));
    send_le32(pick_extreme());
    repeat (4) send_byte(8'($urandom));
  endtask

  task automatic test_bad_magic();
    logic [31:0] magic;
    magic = TAG_HXVS ^ (32'(8'($urandom_range(1, 255))) << (8 * $urandom_range(0, 3)));
    send_tag(magic);
    repeat (RANDOM_BYTES) send_byte(8'($urandom));
  endtask

  task automatic test_audio_lengths();
    send_record(TAG_HXAF, 32'd0, 32'hFFFF_FFF0, 0, 8'h00);
    send_record(TAG_HXAF, 32'd3, 32'h0000_0010, 0, 8'h00);
    send_record(TAG_HXAF, 32'd4, 32'hFFFF_FFFF, 0, 8'h00);
    send_record(TAG_HXAF, 32'h8000_0005, 32'h7FFF_FFF0, 0, 8'h00);
    send_record(TAG_HXAF, 32'd5, 32'h8000_0000, 1, 8'h00);
    send_record(TAG_HXAF, 32'd7, 32'h0000_0000, 3, 8'h00);
  endtask

  task automatic test_video_nal_types();
    logic [7:0] nals[9];
    nals = '{8'h06, 8'h07, 8'h08, 8'hE6, 8'hC8, 8'h05, 8'h1F, 8'h00, 8'hFF};
    // first video record is too short for a time but still sets the reference
    send_record(TAG_HXVF, 32'd4, 32'h8000_0000, 4, 8'h00);
    send_record(TAG_HXVF, 32'd0, 32'h0000_0001, 0, 8'h00);
    send_record(TAG_HXVF, 32'hFFFF_FFFF, 32'h0000_0002, 0, 8'h00);
    foreach (nals[i])
      send_record(TAG_HXVF, 32'd5 + (i % 2), (i == 0) ? 32'h7FFF_FFFF : 32'h8000_0000 + i,
                  5 + (i % 2), nals[i]);
  endtask

  task automatic test_unknown_codes();
    send_record(TAG_HXVS, 32'hFFFF_FFFF, 32'd0, 0, 8'h00);
    send_record(32'h0000_0000, 32'h0000_0000, 32'd0, 0, 8'h00);
    send_record(32'hFFFF_FFFF, 32'h8000_0000, 32'd0, 0, 8'h00);
    send_record(TAG_HXFI ^ 32'd1, 32'h7FFF_FFFF, 32'd0, 0, 8'h00);
  endtask

  task automatic test_random_records();
    int unsigned start;
    int unsigned r;
    int unsigned n_pay;
    logic [31:0] tag;
    logic [31:0] len;
    start = bytes_sent;
    audio_clock = $urandom;
    video_clock = $urandom;
    while (bytes_sent - start < RANDOM_BYTES) begin
      if ($urandom_range(0, 19) == 0) tx_steady = !tx_steady;
      if ($urandom_range(0, 19) == 0) rx_steady = !rx_steady;
      r = $urandom_range(0, 99);
      if (r < 40) begin
        len = audio_length();
        audio_clock = next_time(audio_clock);
        send_record(TAG_HXAF, len, audio_clock, payload_bytes(TAG_HXAF, len), 8'h00);
      end else if (r < 80) begin
        len = video_length();
        video_clock = next_time(video_clock);
        send_record(TAG_HXVF, len, video_clock, payload_bytes(TAG_HXVF, len), nal_byte());
      end else if (r < 88) begin
        send_record(unknown_code(), $urandom, 32'd0, 0, 8'h00);
      end else if (r < 94) begin
        // record cut short, the rest of its payload is padded by resync
        tag = ($urandom_range(0, 1) == 0) ? TAG_HXAF : TAG_HXVF;
        len = $urandom_range(10, 40);
        n_pay = payload_bytes(tag, len) - $urandom_range(1, 5);
        audio_clock = next_time(audio_clock);
        send_record(tag, len, audio_clock, n_pay, nal_byte());
        resync();
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
        resync();
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  task automatic test_end_code();
    resync();
    send_record(TAG_HXFI, $urandom, 32'd0, 0, 8'h00);
  endtask

  task automatic test_ignored_after_end();
    repeat (64) send_byte(8'($urandom));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    if ($urandom_range(0, 7) == 0) begin
      test_bad_magic();
    end else begin
      test_file_header();
      test_audio_lengths();
      test_video_nal_types();
      test_unknown_codes();
      test_random_records();
      test_end_code();
      test_ignored_after_end();
    end
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
